/* hdl/abf_pkg.sv */
// ============================================================================
// abf_pkg: shared types and constants for the allocation bitmap
// Word layout, request/response word formats, mode codes, FSM states and
// the lowest-set-bit search used during scans.
// ============================================================================
package abf_pkg;

	localparam int MAX_BITS    = 1024;
	localparam int WORD_BITS   = 64;
	localparam int WORD_COUNT  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int INDEX_W     = $clog2(MAX_BITS);
	localparam int COUNT_W     = INDEX_W + 1;
	localparam int BIT_SEL_W   = $clog2(WORD_BITS);
	localparam int WORD_SEL_W  = INDEX_W - BIT_SEL_W;
	localparam int MODE_W      = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_BITS);
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

	// request modes
	typedef enum logic [MODE_W-1:0] {
		MODE_SET       = 4'd0,
		MODE_CLEAR     = 4'd1,
		MODE_TEST      = 4'd2,
		MODE_FIND_SET  = 4'd3,
		MODE_FIND_CLR  = 4'd4,
		MODE_SET_ALL   = 4'd5,
		MODE_CLEAR_ALL = 4'd6,
		MODE_ALL_CLR   = 4'd7,
		MODE_ALL_SET   = 4'd8
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BIT,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [INDEX_W-1:0] bit_index;
	} req_word_t;

	typedef struct packed {
		logic               flag;
		logic [INDEX_W-1:0] found_index;
		logic               range_error;
	} rsp_word_t;

	// position of the lowest set bit, halving the window each step
	function automatic logic [BIT_SEL_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0] v;
		logic [WORD_BITS-1:0] lo_mask;
		logic [BIT_SEL_W-1:0] p;
		v = w;
		p = '0;
		for (int l = BIT_SEL_W - 1; l >= 0; l--) begin
			lo_mask = {WORD_BITS{1'b1}} >> (WORD_BITS - (1 << l));
			if ((v & lo_mask) == '0) begin
				p[l] = 1'b1;
				v = v >> (1 << l);
			end
		end
		return p;
	endfunction

endpackage

/* hdl/abf_ram.sv */
// ============================================================================
// abf_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ============================================================================
module abf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/allocation_bitmap_find_first.sv */
// ============================================================================
// allocation_bitmap_find_first: allocation bitmap with first-set/clear search
// Bitmap of MAX_BITS marks in a word RAM; set, clear, test, find and
// whole-map operations, one response per request.
// ============================================================================
// Usage:
//   Requests arrive on req/req_valid and are taken when req_stall is low.
//   Each request yields exactly one word on rsp/rsp_valid, held until a
//   cycle with rsp_stall low. Requests are handled one at a time.
//   Steps from the accepting edge to response valid:
//     set/clear/test in range: word read, modify/write, done
//     out-of-range, set all, clear all, unused modes, empty map: done only
//     find and all-bits queries: scan of the live words, then done; the
//       scan reads one RAM word per cycle through the single read port.
//   The input reopens as the response is loaded.
//   Set all / clear all need no RAM pass: a per-word valid bit plus a fill
//   value stand in for the words until each one is written again.
//   Reset (arst_n low) marks all bits set and sets the bit count to 1024;
//   no clearing pass is needed. cfg_wr_en writes the bit count; the user
//   must do so only while idle, as the block does not enforce it.
//   A stalled response does not block the next request: the block works
//   on it and only waits if its own response is ready before the slot frees.
// ============================================================================
module allocation_bitmap_find_first (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  abf_pkg::req_word_t                req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output abf_pkg::rsp_word_t                rsp,
	input  logic                              cfg_wr_en,
	input  logic [abf_pkg::COUNT_W-1:0]       cfg_wr_data
);

	abf_pkg::state_t                      state_q, state_nxt;
	abf_pkg::req_word_t                   req_q;
	abf_pkg::rsp_word_t                   res_q, rsp_q;
	logic                                 rsp_valid_q;
	logic [abf_pkg::COUNT_W-1:0]          bits_in_use_q;
	logic [abf_pkg::WORD_COUNT-1:0]       word_vld_q;
	logic                                 fill_q;
	logic                                 vld_s1;
	logic [abf_pkg::WORD_SEL_W-1:0]       scan_w_q, last_w_q;
	logic [abf_pkg::BIT_SEL_W-1:0]        rem_q;

	logic                                 ram_we, ram_re;
	logic [abf_pkg::WORD_SEL_W-1:0]       ram_waddr, ram_raddr;
	logic [abf_pkg::WORD_BITS-1:0]        ram_wdata, ram_rdata;

	logic                                 accept, out_free;
	logic [abf_pkg::COUNT_W-1:0]          live_n, live_n_m1;
	logic                                 in_range, live_zero;
	logic                                 is_bit_op, is_scan_op, want_one;
	logic [abf_pkg::WORD_SEL_W-1:0]       req_word_sel, q_word_sel;
	logic [abf_pkg::BIT_SEL_W-1:0]        q_bit_sel;
	logic [abf_pkg::WORD_BITS-1:0]        cur_word, target, live_mask, hits;
	logic                                 hit, scan_last;

	abf_ram #(
		.WIDTH (abf_pkg::WORD_BITS),
		.DEPTH (abf_pkg::WORD_COUNT)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// handshake
	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != abf_pkg::ST_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// effective count and range check
	assign live_n    = (bits_in_use_q > abf_pkg::COUNT_MAX) ? abf_pkg::COUNT_MAX : bits_in_use_q;
	assign live_n_m1 = live_n - abf_pkg::COUNT_W'(1);
	assign live_zero = (live_n == '0);
	assign in_range  = ({1'b0, req.bit_index} < live_n);
	assign req_word_sel = req.bit_index[abf_pkg::INDEX_W-1:abf_pkg::BIT_SEL_W];
	assign q_word_sel   = req_q.bit_index[abf_pkg::INDEX_W-1:abf_pkg::BIT_SEL_W];
	assign q_bit_sel    = req_q.bit_index[abf_pkg::BIT_SEL_W-1:0];

	// mode classes of the incoming request
	always_comb begin
		is_bit_op  = 1'b0;
		is_scan_op = 1'b0;
		unique case (req.mode)
			abf_pkg::MODE_SET, abf_pkg::MODE_CLEAR, abf_pkg::MODE_TEST:
				is_bit_op = 1'b1;
			abf_pkg::MODE_FIND_SET, abf_pkg::MODE_FIND_CLR,
			abf_pkg::MODE_ALL_CLR, abf_pkg::MODE_ALL_SET:
				is_scan_op = 1'b1;
			default: ;
		endcase
	end

	// search polarity of the held request: look for ones or for zeros
	always_comb begin
		unique case (req_q.mode)
			abf_pkg::MODE_FIND_SET, abf_pkg::MODE_ALL_CLR: want_one = 1'b1;
			default:                                       want_one = 1'b0;
		endcase
	end

	// current word, invalid words read as the fill value
	assign cur_word  = vld_s1 ? ram_rdata : {abf_pkg::WORD_BITS{fill_q}};
	assign target    = want_one ? cur_word : ~cur_word;
	assign scan_last = (scan_w_q == last_w_q);
	assign live_mask = (scan_last && rem_q != '0)
		? ((abf_pkg::WORD_BITS'(1) << rem_q) - abf_pkg::WORD_BITS'(1))
		: {abf_pkg::WORD_BITS{1'b1}};
	assign hits = target & live_mask;
	assign hit  = |hits;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			abf_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_bit_op && in_range)
						state_nxt = abf_pkg::ST_BIT;
					else if (is_scan_op && !live_zero)
						state_nxt = abf_pkg::ST_SCAN;
					else
						state_nxt = abf_pkg::ST_DONE;
				end
			end
			abf_pkg::ST_BIT:  state_nxt = abf_pkg::ST_DONE;
			abf_pkg::ST_SCAN: begin
				if (hit || scan_last)
					state_nxt = abf_pkg::ST_DONE;
			end
			abf_pkg::ST_DONE: begin
				if (out_free)
					state_nxt = abf_pkg::ST_IDLE;
			end
			default: state_nxt = abf_pkg::ST_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = q_word_sel;
		ram_wdata = cur_word;
		unique case (state_q)
			abf_pkg::ST_IDLE: begin
				if (accept && ((is_bit_op && in_range) || (is_scan_op && !live_zero))) begin
					ram_re    = 1'b1;
					ram_raddr = is_bit_op ? req_word_sel : '0;
				end
			end
			abf_pkg::ST_BIT: begin
				if (req_q.mode == abf_pkg::MODE_SET || req_q.mode == abf_pkg::MODE_CLEAR) begin
					ram_we = 1'b1;
					ram_wdata[q_bit_sel] = (req_q.mode == abf_pkg::MODE_SET);
				end
			end
			abf_pkg::ST_SCAN: begin
				if (!hit && !scan_last) begin
					ram_re    = 1'b1;
					ram_raddr = scan_w_q + abf_pkg::WORD_SEL_W'(1);
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= abf_pkg::ST_IDLE;
			rsp_valid_q   <= 1'b0;
			bits_in_use_q <= abf_pkg::COUNT_RESET;
			word_vld_q    <= '0;
			fill_q        <= 1'b1;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en)
				bits_in_use_q <= cfg_wr_data;
			// whole-map fill: drop every word back to the fill value
			if (accept && (req.mode == abf_pkg::MODE_SET_ALL ||
				req.mode == abf_pkg::MODE_CLEAR_ALL)) begin
				word_vld_q <= '0;
				fill_q     <= (req.mode == abf_pkg::MODE_SET_ALL);
			end
			if (ram_we)
				word_vld_q[ram_waddr] <= 1'b1;
			// output register
			if (state_q == abf_pkg::ST_DONE && out_free)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ram_re)
			vld_s1 <= word_vld_q[ram_raddr];
		if (state_q == abf_pkg::ST_DONE && out_free)
			rsp_q <= res_q;
		unique case (state_q)
			abf_pkg::ST_IDLE: begin
				if (accept) begin
					req_q    <= req;
					scan_w_q <= '0;
					last_w_q <= live_n_m1[abf_pkg::INDEX_W-1:abf_pkg::BIT_SEL_W];
					rem_q    <= live_n[abf_pkg::BIT_SEL_W-1:0];
					// empty map: both whole-map answers are true
					res_q.flag        <= (req.mode == abf_pkg::MODE_ALL_CLR ||
						req.mode == abf_pkg::MODE_ALL_SET) && live_zero;
					res_q.found_index <= '0;
					res_q.range_error <= is_bit_op && !in_range;
				end
			end
			abf_pkg::ST_BIT: begin
				res_q.flag <= (req_q.mode == abf_pkg::MODE_TEST) && cur_word[q_bit_sel];
			end
			abf_pkg::ST_SCAN: begin
				if (hit) begin
					if (req_q.mode == abf_pkg::MODE_FIND_SET ||
						req_q.mode == abf_pkg::MODE_FIND_CLR) begin
						res_q.flag        <= 1'b1;
						res_q.found_index <= {scan_w_q, abf_pkg::lowest_set(hits)};
					end else begin
						res_q.flag <= 1'b0;
					end
				end else if (scan_last) begin
					res_q.flag <= (req_q.mode == abf_pkg::MODE_ALL_CLR ||
						req_q.mode == abf_pkg::MODE_ALL_SET);
				end else begin
					scan_w_q <= scan_w_q + abf_pkg::WORD_SEL_W'(1);
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// store is written only in the modify step of a bit request
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == abf_pkg::ST_BIT))
		else $error("bitmap write outside modify step");

	// scan never runs past the last live word
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == abf_pkg::ST_SCAN) |-> (scan_w_q <= last_w_q))
		else $error("scan beyond last live word");

	// a finished request with a free slot lands in the output and frees the block
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == abf_pkg::ST_DONE && out_free) |=>
			(rsp_valid_q && state_q == abf_pkg::ST_IDLE))
		else $error("result not delivered from done state");

	// a waiting response is not disturbed by work on the next request
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("stalled response overwritten");

	// a found index is always below the live count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == abf_pkg::ST_DONE && res_q.flag &&
			(req_q.mode == abf_pkg::MODE_FIND_SET || req_q.mode == abf_pkg::MODE_FIND_CLR))
		|-> ({1'b0, res_q.found_index} < live_n))
		else $error("found index outside live range");
`endif

endmodule
